[sv/fpba_pkg.sv]
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and default sizes of the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	// Default sizing of the capacity table.
	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// Fixed field widths of the stream and configuration words.
	localparam int INDEX_W     = 4;
	localparam int AMOUNT_W    = 16;
	localparam int TDATA_W     = 24;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 5;
	localparam int POLICY_W    = 2;
	localparam int COUNT_W     = 5;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	// Placement rules. The unused code behaves as first fit.
	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	// Input word kinds.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} fpba_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // latch the request size and restart the scan
		logic scan;    // scan phase: issue table reads while any remain
		logic load;    // write a loaded capacity into the table
		logic finish;  // write back the chosen entry and latch the result
	} fpba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rd_more; // table reads remain to be issued
	} fpba_status_t;

endpackage

[sv/fit_policy_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Memory block allocator with first, best and worst fit placement rules.
// ----------------------------------------------------------------------------
// A load word produces no result. A request word is accepted, then reads
// one table entry per block in use through the single read port, finishes
// the last compare, and then writes back and registers the result.
// One word is in work at a time; a finished result may wait at the output.
// arst_n clears the controller and configuration; the table is undefined.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_top #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [fpba_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fpba_pkg::TDATA_W-1:0]      s_tdata,  // block_index[3:0], amount[19:4]
	input  logic                              s_tuser,  // mode
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fpba_pkg::TDATA_W-1:0]      m_tdata,  // chosen_block[3:0], capacity_left[19:4]
	output logic                              m_tuser   // granted
);

	fpba_pkg::fpba_cmd_t    cmd;
	fpba_pkg::fpba_status_t status;

	logic [fpba_pkg::INDEX_W-1:0]  res_block;
	logic [fpba_pkg::AMOUNT_W-1:0] res_capacity;

	// The controller owns the handshakes and the result valid flag; the
	// datapath holds the capacity table, the scan comparator and the payload.
	fpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	fpba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_block_index (s_tdata[3:0]),
		.in_amount      (s_tdata[19:4]),
		.cmd            (cmd),
		.status         (status),
		.res_granted    (m_tuser),
		.res_block      (res_block),
		.res_capacity   (res_capacity)
	);

	// The result word is packed with zero padding to whole bytes.
	assign m_tdata = {4'b0000, res_capacity, res_block};

endmodule

[sv/fpba_ram.sv]
// ----------------------------------------------------------------------------
// fpba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/fpba_ctrl.sv]
// ----------------------------------------------------------------------------
// fpba_ctrl
// Controller of the allocator: sequences loads, table scans and results.
// ----------------------------------------------------------------------------
module fpba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_mode,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fpba_pkg::fpba_cmd_t   cmd,
	input  fpba_pkg::fpba_status_t status
);

	fpba_pkg::fpba_state_t state_q, state_d;
	logic out_vld_q;
	logic out_free;

	// The result register can take a new word when empty or being drained.
	assign out_free = !out_vld_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpba_pkg::ST_IDLE: begin
				if (in_valid && (in_mode == fpba_pkg::MODE_ALLOC)) begin
					state_d = fpba_pkg::ST_SCAN;
				end
			end
			fpba_pkg::ST_SCAN: begin
				if (!status.rd_more) begin
					state_d = fpba_pkg::ST_RESULT;
				end
			end
			fpba_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = fpba_pkg::ST_IDLE;
				end
			end
			default: state_d = fpba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			fpba_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.start  = in_valid && (in_mode == fpba_pkg::MODE_ALLOC);
				cmd.load   = in_valid && (in_mode == fpba_pkg::MODE_LOAD);
			end
			fpba_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			fpba_pkg::ST_RESULT: begin
				cmd.finish = out_free;
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fpba_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

endmodule

[sv/fpba_dp.sv]
// ----------------------------------------------------------------------------
// fpba_dp
// Datapath of the allocator: capacity table, scan comparator, result register.
// ----------------------------------------------------------------------------
module fpba_dp #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fpba_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [fpba_pkg::INDEX_W-1:0]       in_block_index,
	input  logic [fpba_pkg::AMOUNT_W-1:0]      in_amount,
	input  fpba_pkg::fpba_cmd_t                cmd,
	output fpba_pkg::fpba_status_t             status,
	output logic                               res_granted,
	output logic [fpba_pkg::INDEX_W-1:0]       res_block,
	output logic [fpba_pkg::AMOUNT_W-1:0]      res_capacity
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int LW = $clog2(NUM_BLOCKS + 1);

	// Configuration registers.
	logic [fpba_pkg::POLICY_W-1:0] fit_policy_q;
	logic [fpba_pkg::COUNT_W-1:0]  block_count_q;

	// Scan state.
	logic [SIZE_BITS-1:0] amt_q;
	logic [LW-1:0]        rd_idx_q;
	logic                 cmp_vld_s1;
	logic [AW-1:0]        cmp_idx_s1;
	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	logic [SIZE_BITS-1:0] best_cap_q;

	// Result register.
	logic                          out_granted_q;
	logic [fpba_pkg::INDEX_W-1:0]  out_block_q;
	logic [fpba_pkg::AMOUNT_W-1:0] out_cap_q;

	logic [LW-1:0]                            limit;
	logic [SIZE_BITS+fpba_pkg::AMOUNT_W-1:0]  amt_wide;
	logic [SIZE_BITS-1:0]                     in_amt;
	logic [AW+fpba_pkg::INDEX_W-1:0]          load_wide;
	logic [AW-1:0]                            load_addr;
	logic                                     load_ok;
	logic [AW+fpba_pkg::INDEX_W-1:0]          pick_wide;
	logic [SIZE_BITS+fpba_pkg::AMOUNT_W-1:0]  left_wide;
	logic [SIZE_BITS-1:0]                     left;
	logic [SIZE_BITS-1:0]                     rd_data;
	logic                                     rd_en;
	logic                                     fits;
	logic                                     better;
	logic                                     take;
	logic                                     ram_we;
	logic [AW-1:0]                            ram_waddr;
	logic [SIZE_BITS-1:0]                     ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= '0;
			block_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpba_pkg::REG_FIT_POLICY:  fit_policy_q  <= cfg_data[fpba_pkg::POLICY_W-1:0];
				fpba_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Blocks in use, saturated at the table depth.
	assign limit = (32'(block_count_q) > NUM_BLOCKS) ? LW'(NUM_BLOCKS) : LW'(block_count_q);

	// Amounts are taken modulo 2^SIZE_BITS.
	assign amt_wide = {{SIZE_BITS{1'b0}}, in_amount};
	assign in_amt   = amt_wide[SIZE_BITS-1:0];

	assign load_wide = {{AW{1'b0}}, in_block_index};
	assign load_addr = load_wide[AW-1:0];
	assign load_ok   = 32'(in_block_index) < NUM_BLOCKS;

	assign status.rd_more = rd_idx_q < limit;
	assign rd_en          = cmd.scan && status.rd_more;

	// One comparator looks at one table entry per cycle.
	assign fits   = rd_data >= amt_q;
	assign better = ((fit_policy_q == fpba_pkg::POLICY_BEST)  && (rd_data < best_cap_q)) ||
	                ((fit_policy_q == fpba_pkg::POLICY_WORST) && (rd_data > best_cap_q));
	assign take   = cmp_vld_s1 && fits && (!found_q || better);

	assign left      = best_cap_q - amt_q;
	assign left_wide = {{fpba_pkg::AMOUNT_W{1'b0}}, left};
	assign pick_wide = {{fpba_pkg::INDEX_W{1'b0}}, best_idx_q};

	assign ram_we    = (cmd.load && load_ok) || (cmd.finish && found_q);
	assign ram_waddr = cmd.load ? load_addr : best_idx_q;
	assign ram_wdata = cmd.load ? in_amt : left;

	fpba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_BLOCKS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q      <= '0;
			cmp_vld_s1    <= 1'b0;
			found_q       <= 1'b0;
			out_granted_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (cmd.start) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + LW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_granted_q <= found_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			amt_q <= in_amt;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (take) begin
			best_idx_q <= cmp_idx_s1;
			best_cap_q <= rd_data;
		end
		if (cmd.finish) begin
			out_block_q <= found_q ? pick_wide[fpba_pkg::INDEX_W-1:0] : '0;
			out_cap_q   <= found_q ? left_wide[fpba_pkg::AMOUNT_W-1:0] : '0;
		end
	end

	assign res_granted  = out_granted_q;
	assign res_block    = out_block_q;
	assign res_capacity = out_cap_q;

endmodule

[verif/tb_fit_policy_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator_top
// Self-checking regression for the fit-policy block allocator.
// ----------------------------------------------------------------------------
// A short table of directed words runs first. It covers an empty block set, a
// zero size, full-scale sizes and capacities, and every placement rule,
// including the spare code. It also covers ties under best and worst fit, a
// request that no block can satisfy, and a load beyond the blocks in use.
// Random phases follow. Each phase sets a new rule and block count, the
// saturating counts among them, and mixes loads and requests. A local model
// of the capacity table predicts every grant. Both stream sides idle in
// random bursts, and once the result side holds off long enough to back the
// block up.
// ----------------------------------------------------------------------------
module tb_fit_policy_block_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCKS = fpba_pkg::NUM_BLOCKS_DEF;
	// Policy code 3 is not named in the package; the block treats it as first fit.
	localparam logic [fpba_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;
	// Long enough that any word still in work runs out.
	localparam int SETTLE_CYCLES = BLOCKS + 6;
	localparam int RANDOM_PHASES = 14;
	localparam int WORDS_PER_PHASE = 100;
	localparam int QUIET_PHASES = 2;
	localparam int HOLD_AFTER_RESULTS = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;

	// One result word: the granted flag, the chosen block and the capacity left.
	typedef struct packed {
		logic                          granted;
		logic [fpba_pkg::INDEX_W-1:0]  block;
		logic [fpba_pkg::AMOUNT_W-1:0] left;
	} grant_t;

	typedef enum logic {
		ROW_WORD,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table: either a register write or an input word.
	// A request row may carry a hand-written result, which then replaces the
	// prediction.
	typedef struct packed {
		row_kind_t                        kind;
		logic [fpba_pkg::CFG_INDEX_W-1:0] reg_sel;
		logic [fpba_pkg::CFG_DATA_W-1:0]  reg_val;
		logic                             mode;
		logic [fpba_pkg::INDEX_W-1:0]     idx;
		logic [fpba_pkg::AMOUNT_W-1:0]    amount;
		logic                             typed;
		grant_t                           want;
	} stim_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [fpba_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [fpba_pkg::TDATA_W-1:0]     s_tdata = '0;
	logic                             s_tuser = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [fpba_pkg::TDATA_W-1:0]     m_tdata;
	logic                             m_tuser;

	// Local copy of the block's state and configuration, kept in step with
	// every accepted word and every register write.
	logic [fpba_pkg::AMOUNT_W-1:0] capacity_tbl [BLOCKS];
	logic [fpba_pkg::POLICY_W-1:0] policy_q = fpba_pkg::POLICY_FIRST;
	logic [fpba_pkg::COUNT_W-1:0]  count_q = '0;

	// Grants that are still owed by the block, oldest first.
	grant_t grant_q [$];

	int  errors = 0;
	int  loads_sent = 0;
	int  requests_sent = 0;
	int  results_seen = 0;
	int  grants_seen = 0;
	int  settings_used = 0;
	bit  no_idle = 1'b0;

	fit_policy_block_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #2 clk = ~clk;

	// The prediction of one request scans the blocks in use once. The scan
	// saturates at the table size. First fit, and the spare code, stop at the
	// first block that fits. Best and worst fit replace the pick only on a
	// strictly better capacity, so ties stay with the lowest index. A granted
	// request shrinks the chosen entry.
	function automatic grant_t predict_request(logic [fpba_pkg::AMOUNT_W-1:0] amt);
		int                            limit;
		bit                            found;
		int                            pick;
		logic [fpba_pkg::AMOUNT_W-1:0] pick_cap;
		grant_t                        g;
		limit = (int'(count_q) > BLOCKS) ? BLOCKS : int'(count_q);
		found = 1'b0;
		pick = 0;
		pick_cap = '0;
		g = '0;
		for (int i = 0; i < limit; i++) begin
			if (capacity_tbl[i] < amt)
				continue;
			if (!found ||
			    (policy_q == fpba_pkg::POLICY_BEST && capacity_tbl[i] < pick_cap) ||
			    (policy_q == fpba_pkg::POLICY_WORST && capacity_tbl[i] > pick_cap)) begin
				found = 1'b1;
				pick = i;
				pick_cap = capacity_tbl[i];
				if (policy_q != fpba_pkg::POLICY_BEST && policy_q != fpba_pkg::POLICY_WORST)
					break;
			end
		end
		if (found) begin
			capacity_tbl[pick] = pick_cap - amt;
			g.granted = 1'b1;
			g.block = pick[fpba_pkg::INDEX_W-1:0];
			g.left = pick_cap - amt;
		end
		return g;
	endfunction

	function automatic stim_row_t cfg_row(logic [fpba_pkg::CFG_INDEX_W-1:0] sel,
	                                      logic [fpba_pkg::CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	function automatic stim_row_t word_row(logic mode, logic [fpba_pkg::INDEX_W-1:0] idx,
	                                       logic [fpba_pkg::AMOUNT_W-1:0] amt);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.mode = mode;
		r.idx = idx;
		r.amount = amt;
		return r;
	endfunction

	function automatic stim_row_t checked_row(logic [fpba_pkg::AMOUNT_W-1:0] amt, logic g,
	                                          logic [fpba_pkg::INDEX_W-1:0] b,
	                                          logic [fpba_pkg::AMOUNT_W-1:0] l);
		stim_row_t r;
		r = word_row(fpba_pkg::MODE_ALLOC, 4'hF, amt);
		r.typed = 1'b1;
		r.want = '{granted: g, block: b, left: l};
		return r;
	endfunction

	// Register writes happen only while the block is idle. The model's copy
	// follows at once, since no word is in work.
	task automatic write_reg(logic [fpba_pkg::CFG_INDEX_W-1:0] sel,
	                         logic [fpba_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (sel == fpba_pkg::REG_FIT_POLICY)
			policy_q = val[fpba_pkg::POLICY_W-1:0];
		else
			count_q = val[fpba_pkg::COUNT_W-1:0];
		settings_used++;
	endtask

	// Lowers valid, waits for every owed grant, then lets a last load or
	// request run out inside the block.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (grant_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Offers one word and keeps it on the bus until it is taken. Valid stays
	// high between back-to-back words; a random gap lowers it now and then.
	task automatic send_word(logic mode, logic [fpba_pkg::INDEX_W-1:0] idx,
	                         logic [fpba_pkg::AMOUNT_W-1:0] amt, logic typed,
	                         grant_t want);
		grant_t g;
		if (!no_idle && $urandom_range(0, 6) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {{(fpba_pkg::TDATA_W - fpba_pkg::AMOUNT_W - fpba_pkg::INDEX_W){1'b0}},
		            amt, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (mode == fpba_pkg::MODE_LOAD) begin
			capacity_tbl[idx] = amt;
			loads_sent++;
		end else begin
			g = predict_request(amt);
			if (typed)
				g = want;
			grant_q.push_back(g);
			requests_sent++;
		end
	endtask

	// Result side: random stall bursts with calm stretches in between. Once,
	// after a couple of hundred results, it holds off for a long stretch while
	// the sender keeps offering words, so the block fills and stalls its input.
	initial begin
		int   stall_left;
		int   calm_left;
		int   hold_left;
		bit   held_once;
		logic rdy;
		stall_left = 0;
		calm_left = 0;
		hold_left = 0;
		held_once = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_once && results_seen >= HOLD_AFTER_RESULTS) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				if (calm_left > 0) begin
					calm_left--;
				end else if (!no_idle && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 11);
					calm_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
				end
			end
			m_tready <= rdy;
		end
	end

	// Every result word taken off the bus is checked against the oldest owed grant.
	always @(posedge clk) begin
		grant_t want;
		grant_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{granted: m_tuser, block: m_tdata[3:0], left: m_tdata[19:4]};
			results_seen++;
			if (got.granted)
				grants_seen++;
			if (grant_q.size() == 0) begin
				errors++;
				$display("%0t ns: result word with none expected: granted %0b block %0d left %0d",
				         $time, got.granted, got.block, got.left);
			end else begin
				want = grant_q.pop_front();
				if (got.granted !== want.granted) begin
					errors++;
					$display("%0t ns: granted mismatch, expected %0b, actual %0b",
					         $time, want.granted, got.granted);
				end
				if (got.block !== want.block) begin
					errors++;
					$display("%0t ns: chosen_block mismatch, expected %0d, actual %0d",
					         $time, want.block, got.block);
				end
				if (got.left !== want.left) begin
					errors++;
					$display("%0t ns: capacity_left mismatch, expected %0d, actual %0d",
					         $time, want.left, got.left);
				end
			end
		end
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#2000000;
		$display("fit_policy_block_allocator_top regression: fail");
		$finish;
	end

	initial begin
		stim_row_t                     dir_rows [$];
		stim_row_t                     row;
		int                            order [BLOCKS];
		int                            fixed_counts [6];
		int                            limit;
		int                            j;
		int                            tmp;
		int                            waited;
		logic [fpba_pkg::AMOUNT_W-1:0] amt;

		for (int i = 0; i < BLOCKS; i++)
			capacity_tbl[i] = '0;

		// Nothing is in use after reset, so even a zero size is refused.
		dir_rows.push_back(checked_row(16'd0, 1'b0, 4'd0, 16'd0));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd0, 16'hFFFF));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd1, 16'd0));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd2, 16'd100));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd3, 16'd50));
		// A load above the blocks in use is still stored.
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd15, 16'd1234));
		dir_rows.push_back(cfg_row(fpba_pkg::REG_BLOCK_COUNT, 5'd4));
		// First fit with a zero size, then a full-scale size on the same block.
		dir_rows.push_back(checked_row(16'd0, 1'b1, 4'd0, 16'hFFFF));
		dir_rows.push_back(checked_row(16'hFFFF, 1'b1, 4'd0, 16'd0));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd7, 16'd1));
		dir_rows.push_back(cfg_row(fpba_pkg::REG_FIT_POLICY,
		                           fpba_pkg::CFG_DATA_W'(fpba_pkg::POLICY_BEST)));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd40));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd0));
		dir_rows.push_back(cfg_row(fpba_pkg::REG_FIT_POLICY,
		                           fpba_pkg::CFG_DATA_W'(fpba_pkg::POLICY_WORST)));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd5));
		// No block in use can hold a full-scale size any more.
		dir_rows.push_back(checked_row(16'hFFFF, 1'b0, 4'd0, 16'd0));
		dir_rows.push_back(cfg_row(fpba_pkg::REG_FIT_POLICY,
		                           fpba_pkg::CFG_DATA_W'(POLICY_SPARE)));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd10));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd1, 16'h8000));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'h8000));
		// Equal capacities: best fit and worst fit both settle on the lower index.
		dir_rows.push_back(cfg_row(fpba_pkg::REG_FIT_POLICY,
		                           fpba_pkg::CFG_DATA_W'(fpba_pkg::POLICY_BEST)));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd2, 16'd30));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd3, 16'd30));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd30));
		dir_rows.push_back(cfg_row(fpba_pkg::REG_FIT_POLICY,
		                           fpba_pkg::CFG_DATA_W'(fpba_pkg::POLICY_WORST)));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd0, 16'd500));
		dir_rows.push_back(word_row(fpba_pkg::MODE_LOAD, 4'd1, 16'd500));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd500));
		dir_rows.push_back(cfg_row(fpba_pkg::REG_BLOCK_COUNT, 5'd1));
		dir_rows.push_back(word_row(fpba_pkg::MODE_ALLOC, 4'd0, 16'd1));

		fixed_counts = '{16, 1, 31, 0, 17, 16};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.reg_sel, row.reg_val);
			end else begin
				send_word(row.mode, row.idx, row.amount, row.typed, row.want);
			end
		end

		// Load every entry once, in shuffled order, so that any block count
		// reads only written capacities from here on.
		wait_idle();
		write_reg(fpba_pkg::REG_FIT_POLICY, fpba_pkg::CFG_DATA_W'(fpba_pkg::POLICY_FIRST));
		for (int i = 0; i < BLOCKS; i++)
			order[i] = i;
		for (int i = BLOCKS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < BLOCKS; i++)
			send_word(fpba_pkg::MODE_LOAD, order[i][fpba_pkg::INDEX_W-1:0],
			          16'($urandom()), 1'b0, '0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p >= RANDOM_PHASES - QUIET_PHASES)
				no_idle = 1'b1;
			wait_idle();
			write_reg(fpba_pkg::REG_FIT_POLICY, fpba_pkg::CFG_DATA_W'(p % 4));
			write_reg(fpba_pkg::REG_BLOCK_COUNT,
			          (p < 6) ? fpba_pkg::CFG_DATA_W'(fixed_counts[p]) :
			          fpba_pkg::CFG_DATA_W'($urandom_range(0, 31)));
			limit = (int'(count_q) > BLOCKS) ? BLOCKS : int'(count_q);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if ($urandom_range(0, 9) < 3) begin
					// Multiples of 256 now and then, so that equal capacities occur.
					case ($urandom_range(0, 5))
						0: amt = 16'd0;
						1: amt = 16'hFFFF;
						2, 3: amt = 16'($urandom_range(1, 8) * 256);
						default: amt = 16'($urandom());
					endcase
					send_word(fpba_pkg::MODE_LOAD, 4'($urandom()), amt, 1'b0, '0);
				end else begin
					// Mostly sizes that some block in use can hold.
					case ($urandom_range(0, 9))
						0: amt = 16'd0;
						1: amt = 16'hFFFF;
						2, 3: amt = 16'($urandom());
						default: begin
							if (limit > 0)
								amt = 16'($urandom_range(0,
								      capacity_tbl[$urandom_range(0, limit - 1)]));
							else
								amt = 16'($urandom());
						end
					endcase
					send_word(fpba_pkg::MODE_ALLOC, 4'($urandom()), amt, 1'b0, '0);
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (grant_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (grant_q.size() != 0) begin
			errors += grant_q.size();
			$display("%0t ns: %0d expected result words never arrived",
			         $time, grant_q.size());
		end

		$display("Ran %0d loads and %0d requests over %0d register writes, all four policy codes.",
		         loads_sent, requests_sent, settings_used);
		$display("Checked %0d result words: %0d grants, %0d refusals, %0d errors.",
		         results_seen, grants_seen, results_seen - grants_seen, errors);
		if (errors == 0) begin
			$display("fit_policy_block_allocator_top regression: pass");
		end else begin
			$display("fit_policy_block_allocator_top regression: fail");
		end
		$finish;
	end

endmodule

[files.f]
sv/fpba_pkg.sv
sv/fpba_ram.sv
sv/fpba_ctrl.sv
sv/fpba_dp.sv
sv/fit_policy_block_allocator_top.sv
verif/tb_fit_policy_block_allocator_top.sv
